@@ rtl/ptss_pkg.sv @@
// Shared types and codes for the predicate tuple store scan unit.
`default_nettype none
package ptss_pkg;
  localparam int ARG_W = 32;
  localparam int NARGS = 4;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_COUNT = 2'd2;
  localparam logic [1:0] REQ_SCAN  = 2'd3;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_CLEARED = 3'd1;
  localparam logic [2:0] ST_COUNT   = 3'd2;
  localparam logic [2:0] ST_MATCH   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_DROPPED = 3'd5;

  typedef logic [NARGS-1:0][ARG_W-1:0] args_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pred;
    logic       pred_ok;
    logic [2:0] arity;
    logic [3:0] filter_mask;
    args_t      values;
  } req_t;
endpackage
`default_nettype wire

@@ rtl/ptss_front.sv @@
// Front end: classifies requests and buffers them in a two-entry queue.
`default_nettype none
module ptss_front #(
  parameter int MAX_ARGS = 4,
  parameter int PRED_IDS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire logic [1:0]    req_type,
  input  wire logic [7:0]    pred,
  input  wire logic [2:0]    arity,
  input  wire logic [3:0]    filter_mask,
  input  wire ptss_pkg::args_t values,
  input  wire logic          pop,
  output logic               empty,
  output ptss_pkg::req_t     head
);
  ptss_pkg::req_t q [2];
  ptss_pkg::req_t cls;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;

  always_comb begin
    cls.req_type    = req_type;
    cls.pred        = pred;
    cls.pred_ok     = {2'b00, pred} < 10'(PRED_IDS > 1023 ? 1023 : PRED_IDS)
                      || PRED_IDS > 255;
    cls.arity       = (arity > 3'(MAX_ARGS)) ? 3'(MAX_ARGS) : arity;
    cls.filter_mask = filter_mask;
    cls.values      = values;
  end

  assign req_stall = cnt == 2'd2;
  assign push      = req_valid && !req_stall;
  assign empty     = cnt == 2'd0;
  assign head      = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/ptss_back.sv @@
// Back end: tuple store, per-predicate tables, scan sequencer and result register.
`default_nettype none
module ptss_back #(
  parameter int STORE_DEPTH = 64,
  parameter int PRED_IDS    = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire ptss_pkg::req_t head,
  output logic                pop,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output logic [2:0]          status,
  output logic [6:0]          tuple_count,
  output logic [2:0]          out_arity,
  output ptss_pkg::args_t     args,
  output logic                last
);
  localparam int PE = (PRED_IDS < 256) ? PRED_IDS : 256;
  localparam int PIW = $clog2(PE);
  localparam int PW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WAIT  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_SADDR = 3'd3;
  localparam logic [2:0] S_SCMP  = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [7:0]      tag_mem   [STORE_DEPTH];
  ptss_pkg::args_t row_mem   [STORE_DEPTH];
  logic [2:0]      arity_mem [PE];
  logic [FW-1:0]   count_mem [PE];
  logic [PE-1:0]   known;
  logic [PE-1:0]   cnt_ok;

  logic [2:0]      state;
  ptss_pkg::req_t  cur;
  logic [PW-1:0]   pos;
  logic [FW-1:0]   fill;
  logic [2:0]      pa;
  logic            have_pend;
  ptss_pkg::args_t pend;

  logic [7:0]      tag_rd;
  ptss_pkg::args_t row_rd;
  logic [2:0]      arity_rd;
  logic [FW-1:0]   count_rd;

  logic [PIW-1:0]  pidx;
  logic            out_free;
  logic [2:0]      add_pa;
  ptss_pkg::args_t add_row;
  logic [3:0]      eff;
  logic            hit;
  logic            at_end;

  assign pidx     = cur.pred[PIW-1:0];
  assign out_free = !rsp_valid || !rsp_stall;
  assign pop      = (state == S_IDLE) && !empty;
  assign add_pa   = known[pidx] ? arity_rd : cur.arity;
  assign at_end   = ({1'b0, pos} + (PW+1)'(1)) == (PW+1)'(fill);

  always_comb begin
    for (int i = 0; i < ptss_pkg::NARGS; i++) begin
      add_row[i] = (3'(i) < add_pa) ? cur.values[i] : '0;
      eff[i]     = cur.filter_mask[i] && (3'(i) < pa);
    end
    hit = tag_rd == cur.pred;
    for (int i = 0; i < ptss_pkg::NARGS; i++) begin
      if (eff[i] && row_rd[i] != cur.values[i]) hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tag_rd   <= tag_mem[pos];
    row_rd   <= row_mem[pos];
    arity_rd <= arity_mem[pidx];
    count_rd <= count_mem[pidx];
    if (state == S_LOOK && out_free && cur.req_type == ptss_pkg::REQ_ADD && cur.pred_ok) begin
      if (!known[pidx]) arity_mem[pidx] <= cur.arity;
      if (fill < FW'(STORE_DEPTH)) begin
        tag_mem[fill[PW-1:0]] <= cur.pred;
        row_mem[fill[PW-1:0]] <= add_row;
        count_mem[pidx] <= (cnt_ok[pidx] ? count_rd : '0) + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      known     <= '0;
      cnt_ok    <= '0;
      have_pend <= 1'b0;
      rsp_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) state <= S_WAIT;
        end
        S_WAIT: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            last        <= 1'b1;
            tuple_count <= '0;
            out_arity   <= '0;
            args        <= '0;
            state       <= S_IDLE;
            unique case (cur.req_type)
              ptss_pkg::REQ_ADD: begin
                status <= ptss_pkg::ST_DROPPED;
                if (cur.pred_ok) begin
                  known[pidx] <= 1'b1;
                  if (fill < FW'(STORE_DEPTH)) begin
                    status       <= ptss_pkg::ST_ADDED;
                    fill         <= fill + FW'(1);
                    cnt_ok[pidx] <= 1'b1;
                  end
                end
              end
              ptss_pkg::REQ_CLEAR: begin
                status <= ptss_pkg::ST_CLEARED;
                fill   <= '0;
                cnt_ok <= '0;
              end
              ptss_pkg::REQ_COUNT: begin
                status <= ptss_pkg::ST_COUNT;
                if (cur.pred_ok && cnt_ok[pidx]) tuple_count <= 7'(count_rd);
              end
              ptss_pkg::REQ_SCAN: begin
                status <= ptss_pkg::ST_EMPTY;
                if (cur.pred_ok && known[pidx] && fill != '0) begin
                  rsp_valid <= 1'b0;
                  pa        <= arity_rd;
                  pos       <= '0;
                  have_pend <= 1'b0;
                  state     <= S_SADDR;
                end
              end
              default: ;
            endcase
          end
        end
        S_SADDR: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (!(hit && have_pend && !out_free)) begin
            if (hit) begin
              if (have_pend) begin
                rsp_valid   <= 1'b1;
                status      <= ptss_pkg::ST_MATCH;
                tuple_count <= '0;
                out_arity   <= pa;
                args        <= pend;
                last        <= 1'b0;
              end
              pend      <= row_rd;
              have_pend <= 1'b1;
            end
            if (at_end) begin
              state <= S_SEND;
            end else begin
              pos   <= pos + PW'(1);
              state <= S_SADDR;
            end
          end
        end
        S_SEND: begin
          if (out_free) begin
            rsp_valid   <= 1'b1;
            tuple_count <= '0;
            last        <= 1'b1;
            if (have_pend) begin
              status    <= ptss_pkg::ST_MATCH;
              out_arity <= pa;
              args      <= pend;
            end else begin
              status    <= ptss_pkg::ST_EMPTY;
              out_arity <= '0;
              args      <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/predicate_tuple_store_scan_unit.sv @@
// Top level of the predicate tuple store scan unit.
//
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | req_type pred arity filter_mask value0..3
// rsp     | out       | rsp_valid / rsp_stall  | status tuple_count out_arity out_arg0..3 last
//
// Add, clear and count pass through the wait and lookup states to a registered result.
// A scan reads and compares one store row at a time, alternating address and compare
// states through the registered read port of the tuple memory; a held match can stall it.
// A two-entry request queue lets requests arrive while the back end works.
// Synchronous reset empties the store, counts and known predicates at once.
`default_nettype none
module predicate_tuple_store_scan_unit #(
  parameter int MAX_ARGS    = 4,
  parameter int STORE_DEPTH = 64,
  parameter int PRED_IDS    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  pred,
  input  wire logic [2:0]  arity,
  input  wire logic [3:0]  filter_mask,
  input  wire logic [31:0] value0,
  input  wire logic [31:0] value1,
  input  wire logic [31:0] value2,
  input  wire logic [31:0] value3,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [2:0]       status,
  output logic [6:0]       tuple_count,
  output logic [2:0]       out_arity,
  output logic [31:0]      out_arg0,
  output logic [31:0]      out_arg1,
  output logic [31:0]      out_arg2,
  output logic [31:0]      out_arg3,
  output logic             last
);
  ptss_pkg::args_t values;
  ptss_pkg::args_t args;
  ptss_pkg::req_t  head;
  logic            empty;
  logic            pop;

  assign values = {value3, value2, value1, value0};
  assign out_arg0 = args[0];
  assign out_arg1 = args[1];
  assign out_arg2 = args[2];
  assign out_arg3 = args[3];

  ptss_front #(.MAX_ARGS(MAX_ARGS), .PRED_IDS(PRED_IDS)) u_front (
    .clk, .rst, .req_valid, .req_stall, .req_type, .pred, .arity, .filter_mask,
    .values, .pop, .empty, .head
  );

  ptss_back #(.STORE_DEPTH(STORE_DEPTH), .PRED_IDS(PRED_IDS)) u_back (
    .clk, .rst, .empty, .head, .pop, .rsp_valid, .rsp_stall, .status, .tuple_count,
    .out_arity, .args, .last
  );

  a_last_non_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ptss_pkg::ST_MATCH |-> last) else $error("non-match not last");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ptss_pkg::ST_COUNT |-> tuple_count <= 7'(STORE_DEPTH))
    else $error("count beyond store depth");
  a_args_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ptss_pkg::ST_MATCH |-> out_arity == 3'd0 && out_arg0 == 32'd0)
    else $error("args on non-match");
endmodule
`default_nettype wire
